>>> rtl/core/jsu_pkg.sv
// Shared types, character codes and helpers for the JSON string unescaper.
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_FAIL  = 2'd3;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_LC_N   = 8'h6e;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;

    // UTF-8 lead and continuation marks
    localparam logic [7:0] UTF_LEAD2 = 8'hc0;
    localparam logic [7:0] UTF_LEAD3 = 8'he0;
    localparam logic [7:0] UTF_CONT  = 8'h80;

    // Bundle slots: at most five data bytes and one closing result per item
    localparam int unsigned DATA_SLOTS = 5;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Everything one input item produces, handed from front to back
    typedef struct packed {
        logic [DATA_SLOTS-1:0][7:0] data;
        logic [2:0]                 n_data;
        logic                       term_v;
        logic [1:0]                 term_kind;
    } t_bundle;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        nibble = v[3:0];
    endfunction

endpackage

>>> rtl/core/jsu_front.sv
// Front end: accepts source bytes, runs the decode state and builds result bundles.
module jsu_front
    import jsu_pkg::*;
#(
    parameter int unsigned CAP_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_in_byte,
    input  logic             i_start_req,
    input  logic [CAP_W-1:0] i_cap_used,
    input  logic             i_q_full,
    output logic             o_push,
    output t_bundle          o_bundle
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TEXT = 4'b0010,
        ST_ESC  = 4'b0100,
        ST_HEX  = 4'b1000
    } t_mode;

    typedef enum logic [1:0] {
        POST_NONE,
        POST_FIN,
        POST_ESC
    } t_post;

    t_mode              r_mode, n_mode;
    logic [1:0]         r_hc, n_hc;
    logic [23:0]        r_dig, n_dig;
    logic [CAP_W-1:0]   r_cnt, n_cnt;
    logic               r_ne, n_ne;

    t_mode              s_mode, keep_mode;
    logic [1:0]         s_hc;
    logic [23:0]        s_dig;
    logic [CAP_W-1:0]   s_cnt;
    logic [CAP_W:0]     s_room;
    logic               room_low;
    logic               s_ne;
    logic [DATA_SLOTS-1:0][7:0] p_bytes;
    logic [2:0]         p_n, base, k;
    t_post              post;
    logic               do_text, early_empty, fail, cap_hit, done;
    logic [15:0]        cp;
    logic               accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // Work out the puts and the closing action this byte asks for
    always_comb begin
        s_mode = i_start_req ? ST_TEXT : r_mode;
        s_cnt  = i_start_req ? '0 : r_cnt;
        s_ne   = i_start_req ? 1'b0 : r_ne;
        s_hc   = i_start_req ? 2'd0 : r_hc;
        s_dig  = i_start_req ? 24'd0 : r_dig;

        // room left before the area is full, signed; the capacity may change mid-string
        s_room   = {1'b0, i_cap_used} - {1'b0, s_cnt} - (CAP_W+1)'(1);
        room_low = s_room[CAP_W] || (s_room == '0);

        p_bytes     = '0;
        p_n         = 3'd0;
        base        = 3'd0;
        post        = POST_NONE;
        keep_mode   = s_mode;
        do_text     = 1'b0;
        early_empty = 1'b0;
        fail        = 1'b0;
        n_hc        = s_hc;
        n_dig       = s_dig;
        cp          = {nibble(s_dig[7:0]), nibble(s_dig[15:8]), nibble(s_dig[23:16]),
                       nibble(i_in_byte)};

        if (i_start_req && i_cap_used <= CAP_W'(1)) begin
            early_empty = 1'b1;
        end else begin
            case (s_mode)
                ST_TEXT: begin
                    do_text = 1'b1;
                end
                ST_ESC: begin
                    keep_mode = ST_TEXT;
                    p_n       = 3'd1;
                    case (i_in_byte)
                        CH_NUL: begin
                            p_bytes[0] = CH_BSLASH;
                            post       = POST_FIN;
                        end
                        CH_LC_N: p_bytes[0] = CH_LF;
                        CH_LC_R: p_bytes[0] = CH_CR;
                        CH_LC_T: p_bytes[0] = CH_TAB;
                        CH_LC_B: p_bytes[0] = CH_BS;
                        CH_LC_F: p_bytes[0] = CH_FF;
                        CH_LC_U: begin
                            keep_mode = ST_HEX;
                            p_n       = 3'd0;
                            n_hc      = 2'd0;
                            n_dig     = 24'd0;
                        end
                        default: p_bytes[0] = i_in_byte;
                    endcase
                end
                ST_HEX: begin
                    if (is_hex(i_in_byte)) begin
                        if (s_hc != 2'd3) begin
                            // buffer the digit, first digit lowest
                            n_hc = s_hc + 2'd1;
                            case (s_hc)
                                2'd0:    n_dig[7:0]   = i_in_byte;
                                2'd1:    n_dig[15:8]  = i_in_byte;
                                default: n_dig[23:16] = i_in_byte;
                            endcase
                        end else begin
                            n_hc  = 2'd0;
                            n_dig = 24'd0;
                            if (s_room[CAP_W] || s_room <= (CAP_W+1)'(3)) begin
                                fail = 1'b1;
                            end else begin
                                keep_mode = ST_TEXT;
                                if (cp < 16'h0080) begin
                                    p_bytes[0] = cp[7:0];
                                    p_n        = 3'd1;
                                end else if (cp < 16'h0800) begin
                                    p_bytes[0] = UTF_LEAD2 | {3'b000, cp[10:6]};
                                    p_bytes[1] = UTF_CONT | {2'b00, cp[5:0]};
                                    p_n        = 3'd2;
                                end else begin
                                    p_bytes[0] = UTF_LEAD3 | {4'b0000, cp[15:12]};
                                    p_bytes[1] = UTF_CONT | {2'b00, cp[11:6]};
                                    p_bytes[2] = UTF_CONT | {2'b00, cp[5:0]};
                                    p_n        = 3'd3;
                                end
                            end
                        end
                    end else begin
                        // bad digit: '?', replay buffered digits, then plain text
                        keep_mode  = ST_TEXT;
                        n_hc       = 2'd0;
                        n_dig      = 24'd0;
                        p_bytes[0] = CH_QMARK;
                        p_bytes[1] = s_dig[7:0];
                        p_bytes[2] = s_dig[15:8];
                        p_bytes[3] = s_dig[23:16];
                        base       = 3'd1 + {1'b0, s_hc};
                        p_n        = base;
                        do_text    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // ordinary text byte, placed after anything already queued up
        if (do_text) begin
            if (i_in_byte == CH_NUL || i_in_byte == CH_QUOTE) begin
                post = POST_FIN;
            end else if (i_in_byte == CH_BSLASH) begin
                post = POST_ESC;
            end else begin
                p_bytes[base] = i_in_byte;
                p_n           = base + 3'd1;
            end
        end
    end

    // Trim the puts at the capacity limit and pick the closing result
    always_comb begin
        // with no room left the first put still goes out, then the string closes
        cap_hit = (p_n != 3'd0) && (room_low || ((CAP_W+1)'(p_n) >= s_room));
        k       = cap_hit ? (room_low ? 3'd1 : s_room[2:0]) : p_n;
        done    = cap_hit || (post == POST_FIN);

        o_bundle           = '0;
        o_bundle.data      = p_bytes;
        o_bundle.n_data    = k;
        o_bundle.term_v    = early_empty || fail || done;
        o_bundle.term_kind = early_empty ? KIND_EMPTY :
                             fail        ? KIND_FAIL  :
                             (s_ne || k != 3'd0) ? KIND_DONE : KIND_EMPTY;

        if (early_empty || fail || done) begin
            n_mode = ST_IDLE;
        end else if (post == POST_ESC) begin
            n_mode = ST_ESC;
        end else begin
            n_mode = keep_mode;
        end
        n_cnt = s_cnt + CAP_W'(k);
        n_ne  = s_ne || (k != 3'd0);
    end

    assign o_push = accept && (o_bundle.n_data != 3'd0 || o_bundle.term_v);

    // Advance decode state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ST_IDLE;
            r_hc   <= 2'd0;
            r_dig  <= 24'd0;
            r_cnt  <= '0;
            r_ne   <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_hc   <= n_hc;
            r_dig  <= n_dig;
            r_cnt  <= n_cnt;
            r_ne   <= n_ne;
        end
    end

endmodule

>>> rtl/core/jsu_queue.sv
// Short bundle queue between the decode front end and the output back end.
module jsu_queue
    import jsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_wdata,
    input  logic    i_pop,
    output t_bundle o_rdata,
    output logic    o_full,
    output logic    o_empty
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    t_bundle        r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [PW:0]    r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    // Store pushed bundles
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

endmodule

>>> rtl/core/jsu_back.sv
// Back end: unpacks bundles into output beats, one result per beat.
module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_bundle    i_bundle,
    input  logic       i_q_empty,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);

    t_bundle    r_bund;
    logic [2:0] r_idx;
    logic       r_busy;
    logic [2:0] total;
    logic       is_data, beat;

    assign total   = r_bund.n_data + {2'b00, r_bund.term_v};
    assign is_data = (r_idx < r_bund.n_data);
    assign beat    = r_busy && i_out_ready;

    assign o_out_valid = r_busy;
    assign o_out_byte  = is_data ? r_bund.data[r_idx] : 8'h00;
    assign o_kind      = is_data ? KIND_DATA : r_bund.term_kind;
    assign o_last      = (r_idx == total - 3'd1);

    // Load the next bundle when idle or when the final beat leaves
    assign o_pop = !i_q_empty && (!r_busy || (beat && o_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (beat) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 3'd1;
        end
    end

    // Hold the bundle payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bund <= i_bundle;
        end
    end

endmodule

>>> rtl/core/json_string_unescape_utf8_core.sv
// Top level of the JSON string unescaper with UTF-8 output of \u escapes.
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in_byte, i_start_req
//  out       output     o_out_valid / i_out_ready  o_out_byte, o_kind, o_last
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_out_capacity
//
//  One source byte is taken per cycle while the bundle queue has room; the decode
//  of a byte settles in the cycle it is taken.
//  Results leave at one beat per cycle while i_out_ready is high, registered in the
//  queue and back end; bytes with several results (up to six) drain from the queue.
//  Input stalls only when the four-entry queue is full. Reset is synchronous,
//  active low, and leaves the block finished and waiting for a start byte.
module json_string_unescape_utf8_core
    import jsu_pkg::*;
#(
    parameter int unsigned MAX_CAPACITY = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_start_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_kind,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_out_capacity
);

    localparam int unsigned MW    = $clog2(MAX_CAPACITY + 1);
    localparam int unsigned CAP_W = (MW > 13) ? MW : 13;

    logic [12:0]      r_cap;
    logic [CAP_W-1:0] cap_ext, cap_used;
    logic             q_full, q_empty, push, pop;
    t_bundle          f_bundle, q_bundle;

    // Capacity register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 13'd1024;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_out_capacity;
        end
    end

    // Clamp to the largest supported area
    assign cap_ext  = CAP_W'(r_cap);
    assign cap_used = (cap_ext > CAP_W'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY) : cap_ext;

    jsu_front #(
        .CAP_W (CAP_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_start_req (i_start_req),
        .i_cap_used  (cap_used),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_bundle    (f_bundle)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (f_bundle),
        .i_pop   (pop),
        .o_rdata (q_bundle),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bundle    (q_bundle),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

endmodule

>>> rtl/core/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
module jsu_checker
    import jsu_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic [1:0] o_kind,
    input logic       o_last
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_kind) && $stable(o_last))
        else $error("output beat changed while stalled");

    // A closing result always ends the item's results
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_DATA |-> o_last)
        else $error("closing result without last");

    // A closing result carries a zero byte
    a_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_DATA |-> o_out_byte == 8'h00)
        else $error("closing result with nonzero byte");

    // Nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_kind      (o_kind),
    .o_last      (o_last)
);
